// ===== rtl/rlmc_pkg.sv =====
`timescale 1ns / 1ps

package rlmc_pkg;

  // Default sizes of the block.
  localparam int MAX_SIZE_DEF    = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration registers.
  localparam int CFG_W    = 9;
  localparam int CFG_AW   = 1;
  localparam logic [CFG_W-1:0] CFG_SIZE_RST = 9'd256;
  localparam int SIZE_MIN = 3;

  typedef enum logic [CFG_AW-1:0] {
    REG_ROW_LENGTH = 1'b0,
    REG_ROW_TOTAL  = 1'b1
  } reg_idx_e;

  // Result fields.
  localparam int ROW_W   = 8;
  localparam int COUNT_W = 8;
  localparam int OUT_TDATA_W = ROW_W + COUNT_W;

  // Result queue depth: room for the two results of the item in flight
  // plus the two of the item being accepted.
  localparam int RES_DEPTH = 4;

endpackage

// ===== rtl/rlmc_ram.sv =====
`timescale 1ns / 1ps

module rlmc_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/row_local_minima_counter.sv =====
`timescale 1ns / 1ps

// Row local-minima counter. Samples enter in raster order, one beat per
// sample, and the block takes one sample every clock cycle without gaps as
// long as results are drained. It counts, per row, the interior cells whose
// value is no greater than the left and right neighbors and strictly less
// than the cells above and below. At the last sample of row k (k at least 1)
// one result beat reports row k-1; at the last sample of the final row a
// second beat follows with a zero count for the last row and tlast set.
// Both line buffers live in one single-port-read RAM, one word per column
// holding the row above and the center row side by side; each sample does
// one read and one write of its column word, and the compare against the
// neighbors runs in the cycle after acceptance, when the read data is back.
// Results are pushed by the compare stage into a four-entry queue and leave
// from its head; the input stalls only when that queue cannot take the
// results of the items in flight. The RAM needs no clearing pass after
// reset: every entry is written before its contents are used in a compare.
module row_local_minima_counter
  import rlmc_pkg::*;
#(
  parameter int MaxSize    = rlmc_pkg::MAX_SIZE_DEF,
  parameter int SampleBits = rlmc_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,

  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [rlmc_pkg::CFG_AW-1:0]      cfg_addr_i,
  input  logic [rlmc_pkg::CFG_W-1:0]       cfg_data_i,

  // Sample stream.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: sample (zero padded to whole bytes)
  input  logic [((SampleBits+7)/8)*8-1:0]  s_axis_tdata_i,

  // Result stream.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata: row_index [7:0], minima_count [15:8]
  output logic [rlmc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // tlast: last_row
  output logic                             m_axis_tlast_o
);

  localparam int IdxW  = $clog2(MaxSize);
  localparam int LenW  = IdxW + 1;
  localparam int CmpW  = (LenW > CFG_W) ? LenW : CFG_W;
  localparam int PtrW  = $clog2(RES_DEPTH);
  localparam int CntW  = PtrW + 1;

  typedef struct packed {
    logic [IdxW-1:0] col;
    logic [IdxW-1:0] row;
    logic            row_end;
    logic            mat_end;
    logic            emit_row;  // row end of a row other than row 0
    logic            check;     // a cell of the row before is tested at this beat
  } item_ctl_t;

  typedef struct packed {
    logic               last;
    logic [COUNT_W-1:0] count;
    logic [ROW_W-1:0]   row;
  } result_t;

  // Effective size: register value clamped to the supported range.
  function automatic logic [LenW-1:0] clamp_size(input logic [CFG_W-1:0] v);
    logic [CmpW-1:0] ext;
    logic [CmpW-1:0] res;
    ext = CmpW'(v);
    if (ext < CmpW'(SIZE_MIN)) begin
      res = CmpW'(SIZE_MIN);
    end else if (ext > CmpW'(MaxSize)) begin
      res = CmpW'(MaxSize);
    end else begin
      res = ext;
    end
    return LenW'(res);
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] row_length_q, row_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= CFG_SIZE_RST;
      row_total_q  <= CFG_SIZE_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_ROW_LENGTH: row_length_q <= cfg_data_i;
        REG_ROW_TOTAL:  row_total_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Accept stage: stream position and RAM read of the column word.
  // ---------------------------------------------------------------------
  logic [IdxW-1:0] col_q, col_d, row_q, row_d;
  logic [LenW-1:0] len_eff, rows_eff;
  logic            in_acc;
  item_ctl_t       a_ctl;

  assign len_eff  = clamp_size(row_length_q);
  assign rows_eff = clamp_size(row_total_q);
  assign in_acc   = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    a_ctl.col      = col_q;
    a_ctl.row      = row_q;
    a_ctl.row_end  = {1'b0, col_q} >= (len_eff - LenW'(1));
    a_ctl.mat_end  = a_ctl.row_end && ({1'b0, row_q} >= (rows_eff - LenW'(1)));
    a_ctl.emit_row = a_ctl.row_end && (row_q != '0);
    // The beat at column c tests the cell at column c-1 of the center row.
    a_ctl.check    = (row_q >= IdxW'(2)) && (col_q >= IdxW'(2));
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (a_ctl.row_end) begin
        col_d = '0;
        row_d = a_ctl.mat_end ? '0 : row_q + IdxW'(1);
      end else begin
        col_d = col_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------
  // Compare stage: read data returns, neighbors are tested, word written.
  // ---------------------------------------------------------------------
  logic                  b_valid_q;
  item_ctl_t             b_ctl_q;
  logic [SampleBits-1:0] b_sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      b_ctl_q    <= a_ctl;
      b_sample_q <= s_axis_tdata_i[SampleBits-1:0];
    end
  end

  logic [2*SampleBits-1:0] ram_rdata;
  logic [SampleBits-1:0]   above, center;

  // The word of a column is written back in the cycle after its read; the next
  // read of the same column comes a whole row later, so no forwarding.
  rlmc_ram #(
    .Width (2 * SampleBits),
    .Depth (MaxSize)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_ctl_q.col),
    .wdata_i ({center, b_sample_q}),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  assign above  = ram_rdata[2*SampleBits-1:SampleBits];
  assign center = ram_rdata[SampleBits-1:0];

  // Neighborhood of the cell one column back.
  logic [SampleBits-1:0] cell_q, left_q, up_q, down_q;
  logic                  hit;
  logic [COUNT_W-1:0]    tally_q, tally_d, tally_upd;

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      left_q <= cell_q;
      cell_q <= center;
      up_q   <= above;
      down_q <= b_sample_q;
    end
  end

  assign hit = b_valid_q && b_ctl_q.check &&
               (cell_q <= left_q) && (cell_q <= center) &&
               (cell_q < up_q) && (cell_q < down_q);

  assign tally_upd = (hit && (tally_q != '1)) ? tally_q + COUNT_W'(1) : tally_q;

  always_comb begin
    tally_d = tally_q;
    if (b_valid_q) begin
      tally_d = b_ctl_q.row_end ? '0 : tally_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
    end else begin
      tally_q <= tally_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result queue.
  // ---------------------------------------------------------------------
  result_t         res_q [RES_DEPTH];
  result_t         res_row, res_last;
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, n_push, n_b;
  logic            push_row, push_last, pop;

  assign push_row  = b_valid_q && b_ctl_q.emit_row;
  assign push_last = b_valid_q && b_ctl_q.mat_end;
  assign n_push    = CntW'(push_row) + CntW'(push_last);
  assign pop       = m_axis_tvalid_o & m_axis_tready_i;

  assign res_row  = '{last: 1'b0, count: tally_upd, row: ROW_W'(b_ctl_q.row - IdxW'(1))};
  assign res_last = '{last: 1'b1, count: '0, row: ROW_W'(b_ctl_q.row)};

  always_ff @(posedge clk_i) begin
    if (push_row) begin
      res_q[wr_ptr_q] <= res_row;
    end
    if (push_last) begin
      res_q[push_row ? wr_ptr_q + PtrW'(1) : wr_ptr_q] <= res_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      count_q  <= count_q + n_push - CntW'(pop);
    end
  end

  // The item now in the compare stage pushes up to two results next, and a
  // newly accepted one up to two once it reaches the compare stage.
  assign n_b = b_valid_q ? CntW'(b_ctl_q.emit_row) + CntW'(b_ctl_q.mat_end) : '0;
  assign s_axis_tready_o = (count_q + n_b) <= CntW'(RES_DEPTH - 2);

  assign m_axis_tvalid_o = (count_q != '0);
  assign m_axis_tdata_o  = {res_q[rd_ptr_q].count, res_q[rd_ptr_q].row};
  assign m_axis_tlast_o  = res_q[rd_ptr_q].last;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(RES_DEPTH))
    else $error("result queue overflow");

  a_mat_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && b_ctl_q.mat_end |-> b_ctl_q.row_end)
    else $error("matrix end without row end");

  a_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> res_q[rd_ptr_q].count == '0)
    else $error("last-row result with nonzero count");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (count_q + n_push) <= CntW'(RES_DEPTH))
    else $error("results pushed without room");

endmodule
